### src/fmsu_pkg.sv
// Package for the fp64 modf split unit: field widths, constants and types.
// No dependencies.
`default_nettype none
package fmsu_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned MantW = 52;
  localparam int unsigned ExpW  = 11;
  localparam logic [ExpW-1:0]  ExpAll  = 11'h7ff;
  localparam logic [ExpW-1:0]  ExpBias = 11'h3ff;
  localparam logic [WordW-1:0] QnanBits = 64'h7ff8_0000_0000_0000;

  typedef enum logic [1:0] {
    CASE_PASS  = 2'd0,
    CASE_SMALL = 2'd1,
    CASE_NAN   = 2'd2,
    CASE_SPLIT = 2'd3
  } case_t;

  typedef struct packed {
    logic              sign;
    logic [ExpW-1:0]   bexp;
    logic [MantW-1:0]  frac;
    logic [MantW-1:0]  keep_mant;
    logic [5:0]        e;
    case_t             kind;
  } s1_t;
endpackage
`default_nettype wire

### src/fp64_modf_split_unit_top.sv
// fp64 modf split unit top: splits a double into fractional and integer parts.
// Uses fmsu_pkg.
//
// Three-stage pipeline, one transaction per cycle while not stalled. Stage 1
// classifies and masks the mantissa, stage 2 finds the leading one of the
// fraction, stage 3 shifts it up and builds the exponent. A stall freezes all
// stages; a stage that is empty still accepts.
`default_nettype none
module fp64_modf_split_unit_top (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [fmsu_pkg::WordW-1:0] in_value_bits,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [fmsu_pkg::WordW-1:0] out_fraction_bits,
  output logic [fmsu_pkg::WordW-1:0] out_integer_bits
);
  import fmsu_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  s1_t  s1_r, s1_nxt, s2_r;
  logic [5:0] p2_r, p2_nxt;
  logic [WordW-1:0] frac_r, frac_nxt, int_r, int_nxt;

  assign en3 = !v3_r || out_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = v3_r;
  assign out_fraction_bits = frac_r;
  assign out_integer_bits  = int_r;

  always_comb begin
    logic [ExpW-1:0] be;
    logic [MantW-1:0] m, mask;
    logic [ExpW:0] ediff;
    be = in_value_bits[WordW-2 -: ExpW];
    m  = in_value_bits[MantW-1:0];
    ediff = {1'b0, be} - {1'b0, ExpBias};
    s1_nxt.sign = in_value_bits[WordW-1];
    s1_nxt.bexp = be;
    s1_nxt.e = ediff[5:0];
    mask = {MantW{1'b1}} >> ediff[5:0];
    s1_nxt.frac = m & mask;
    s1_nxt.keep_mant = m & ~mask;
    if (be == ExpAll && m != '0) begin
      s1_nxt.kind = CASE_NAN;
    end else if (be >= ExpBias + 11'd52) begin
      s1_nxt.kind = CASE_PASS;
    end else if (be < ExpBias) begin
      s1_nxt.kind = CASE_SMALL;
    end else begin
      s1_nxt.kind = CASE_SPLIT;
    end
  end

  always_comb begin
    p2_nxt = '0;
    for (int i = 0; i < MantW; i++) begin
      if (s1_r.frac[i]) p2_nxt = 6'(i);
    end
  end

  always_comb begin
    logic [MantW-1:0] fm;
    logic [ExpW-1:0] fe;
    fm = s2_r.frac << (6'd52 - p2_r);
    fe = ExpBias - 11'd52 + {5'd0, p2_r} + {5'd0, s2_r.e};
    case (s2_r.kind)
      CASE_NAN: begin
        frac_nxt = QnanBits;
        int_nxt  = QnanBits;
      end
      CASE_PASS: begin
        frac_nxt = {s2_r.sign, 63'd0};
        int_nxt  = {s2_r.sign, s2_r.bexp, s2_r.keep_mant | s2_r.frac};
      end
      CASE_SMALL: begin
        frac_nxt = {s2_r.sign, s2_r.bexp, s2_r.frac | s2_r.keep_mant};
        int_nxt  = {s2_r.sign, 63'd0};
      end
      default: begin
        int_nxt = {s2_r.sign, s2_r.bexp, s2_r.keep_mant};
        if (s2_r.frac == '0) frac_nxt = {s2_r.sign, 63'd0};
        else frac_nxt = {s2_r.sign, fe, fm};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) begin
      s2_r <= s1_r;
      p2_r <= p2_nxt;
    end
    if (en3) begin
      frac_r <= frac_nxt;
      int_r  <= int_nxt;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_integer_bits))
    else $error("result changed under stall");
  a_nan_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_integer_bits == QnanBits |-> out_fraction_bits == QnanBits)
    else $error("nan split mismatch");
  a_sign_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fraction_bits[WordW-1] == out_integer_bits[WordW-1])
    else $error("sign mismatch");
endmodule
`default_nettype wire
